FILE: hw/rtl/dpl_pkg.sv
package dpl_pkg;

   // Segment width; the accumulator and the overflow check follow it (8 to 64).
   localparam int SEG_WIDTH = 32;
   // Width of acc * 10 + digit before the overflow check.
   localparam int ACC_EXT_W = SEG_WIDTH + 4;
   localparam int OUT_W     = 32;

   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef logic [SEG_WIDTH-1:0] seg_type;
   typedef logic [OUT_W-1:0]     out_type;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_PRE,
      PH_DIGITS,
      PH_POST,
      PH_CLOSED
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      braced;
      seg_type   acc;
      logic      failed;
   } state_type;

   typedef struct packed {
      logic    emit;
      out_type value;
      logic    has_seg;
      logic    is_final;
      logic    ok;
   } result_type;

   function automatic out_type seg_to_out(seg_type v);
      logic [63:0] w;
      w = 64'(v);
      return w[OUT_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/dpl_step.sv
// Next-state and result logic for one byte of the path text.
module dpl_step (
   input  dpl_pkg::state_type  cur,
   input  logic [7:0]          char_code,
   input  logic                is_last,
   output dpl_pkg::state_type  nxt,
   output dpl_pkg::result_type res
);

   logic                           is_ws;
   logic                           is_digit;
   logic [3:0]                     digit_val;
   logic [dpl_pkg::ACC_EXT_W-1:0]  prod;
   logic                           ovf;
   logic                           cur_has_digits;
   dpl_pkg::state_type             upd;
   dpl_pkg::state_type             rst_state;

   assign is_ws     = (char_code == dpl_pkg::CH_SPACE) ||
                      ((char_code >= dpl_pkg::CH_TAB) && (char_code <= dpl_pkg::CH_CR));
   assign is_digit  = (char_code >= dpl_pkg::CH_ZERO) && (char_code <= dpl_pkg::CH_NINE);
   assign digit_val = 4'(char_code - dpl_pkg::CH_ZERO);

   // acc * 10 + digit as shifts and adds, with four guard bits for overflow.
   assign prod = ({cur.acc, 3'b000} + {2'b00, cur.acc, 1'b0}) +
                 dpl_pkg::ACC_EXT_W'(digit_val);
   assign ovf  = |prod[dpl_pkg::ACC_EXT_W-1:dpl_pkg::SEG_WIDTH];

   assign cur_has_digits = (cur.phase == dpl_pkg::PH_DIGITS) ||
                           (cur.phase == dpl_pkg::PH_POST);

   always_comb begin
      rst_state.phase  = dpl_pkg::PH_LEAD;
      rst_state.braced = 1'b0;
      rst_state.acc    = '0;
      rst_state.failed = 1'b0;
   end

   // State update for the byte.
   always_comb begin
      dpl_pkg::phase_type ph;
      logic               proceed;
      upd     = cur;
      ph      = cur.phase;
      proceed = !cur.failed;
      if (proceed && (ph == dpl_pkg::PH_LEAD)) begin
         if (is_ws) begin
            proceed = 1'b0;
         end else if (char_code == dpl_pkg::CH_LBRACE) begin
            upd.braced = 1'b1;
            upd.phase  = dpl_pkg::PH_PRE;
            proceed    = 1'b0;
         end else begin
            ph = dpl_pkg::PH_PRE;
         end
      end
      if (proceed) begin
         upd.phase = ph;
         if (char_code == dpl_pkg::CH_SEMI) begin
            if (!((ph == dpl_pkg::PH_DIGITS) || (ph == dpl_pkg::PH_POST))) begin
               upd.failed = 1'b1;
            end
            upd.phase = dpl_pkg::PH_PRE;
         end else begin
            unique case (ph) inside
               dpl_pkg::PH_PRE: begin
                  if (is_digit) begin
                     upd.acc   = dpl_pkg::SEG_WIDTH'(digit_val);
                     upd.phase = dpl_pkg::PH_DIGITS;
                  end else if (!is_ws) begin
                     upd.failed = 1'b1;
                  end
               end
               dpl_pkg::PH_DIGITS, dpl_pkg::PH_POST: begin
                  if (is_ws) begin
                     upd.phase = dpl_pkg::PH_POST;
                  end else if (is_digit && (ph == dpl_pkg::PH_DIGITS)) begin
                     if (ovf) begin
                        upd.failed = 1'b1;
                     end else begin
                        upd.acc = prod[dpl_pkg::SEG_WIDTH-1:0];
                     end
                  end else if ((char_code == dpl_pkg::CH_RBRACE) && cur.braced) begin
                     upd.phase = dpl_pkg::PH_CLOSED;
                  end else begin
                     upd.failed = 1'b1;
                  end
               end
               default: begin
                  if (!is_ws) begin
                     upd.failed = 1'b1;
                  end
               end
            endcase
         end
      end

      if (is_last) begin
         nxt = rst_state;
      end else if (char_code == dpl_pkg::CH_SEMI) begin
         nxt     = upd;
         nxt.acc = '0;
      end else begin
         nxt = upd;
      end
   end

   // Result for the byte.
   always_comb begin
      logic good;
      res  = '0;
      good = 1'b0;
      if (is_last) begin
         good = !upd.failed &&
                (upd.braced ? (upd.phase == dpl_pkg::PH_CLOSED)
                            : ((upd.phase == dpl_pkg::PH_DIGITS) ||
                               (upd.phase == dpl_pkg::PH_POST)));
         res.emit     = 1'b1;
         res.is_final = 1'b1;
         res.ok       = good;
         res.has_seg  = good;
         res.value    = good ? dpl_pkg::seg_to_out(upd.acc) : '0;
      end else if (char_code == dpl_pkg::CH_SEMI) begin
         good        = !cur.failed && cur_has_digits;
         res.emit    = 1'b1;
         res.has_seg = good;
         res.value   = good ? dpl_pkg::seg_to_out(cur.acc) : '0;
      end
   end

endmodule

FILE: hw/rtl/decimal_path_list_parser.sv
// Channel  | Direction | Handshake           | Payload
// req      | in        | req_valid/req_stall | req_char_code[7:0], req_is_last_char
// rsp      | out       | rsp_valid/rsp_stall | rsp_segment_value[31:0], rsp_has_segment,
//          |           |                     | rsp_is_final, rsp_parse_ok
//
// One byte is taken per cycle while req_stall is low; a byte passes through the input
// register and then the result register on its way from a req transfer to the matching rsp transfer.
// The parse state advances once per byte in the step logic between those registers.
// Reset is synchronous and active high; it clears the parse state and both valids.
// A stall on rsp holds only bytes that produce a result (';' or the last byte);
// other bytes keep moving through while a result waits.
module decimal_path_list_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_is_last_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_segment_value,
   output logic        rsp_has_segment,
   output logic        rsp_is_final,
   output logic        rsp_parse_ok
);

   // Input register stage.
   logic                s1_vld_ff;
   logic                s1_vld_in;
   logic [7:0]          s1_char_ff;
   logic                s1_last_ff;

   // Parse state, updated when the byte in the input register moves on.
   dpl_pkg::state_type  state_ff;
   dpl_pkg::state_type  state_in;

   // Result register.
   logic                rsp_vld_ff;
   logic                rsp_vld_in;
   dpl_pkg::result_type rsp_ff;
   dpl_pkg::result_type rsp_in;

   dpl_pkg::state_type  step_nxt;
   dpl_pkg::result_type step_res;
   logic                out_free;
   logic                s1_adv;
   logic                req_take;

   dpl_step u_step (
      .cur       (state_ff),
      .char_code (s1_char_ff),
      .is_last   (s1_last_ff),
      .nxt       (step_nxt),
      .res       (step_res)
   );

   // The result register can take a new result when empty or when its
   // current result transfers in this cycle.
   assign out_free = !rsp_vld_ff || !rsp_stall;

   // A byte without a result never waits on the output side.
   assign s1_adv   = s1_vld_ff && (!step_res.emit || out_free);
   assign req_stall = s1_vld_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_vld_in  = req_take || (s1_vld_ff && !s1_adv);
      state_in   = s1_adv ? step_nxt : state_ff;
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      rsp_in     = rsp_ff;
      if (s1_adv && step_res.emit) begin
         rsp_vld_in = 1'b1;
         rsp_in     = step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff        <= 1'b0;
         rsp_vld_ff       <= 1'b0;
         state_ff.phase   <= dpl_pkg::PH_LEAD;
         state_ff.braced  <= 1'b0;
         state_ff.acc     <= '0;
         state_ff.failed  <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         state_ff   <= state_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_char_code;
         s1_last_ff <= req_is_last_char;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_segment_value = rsp_ff.value;
   assign rsp_has_segment   = rsp_ff.has_seg;
   assign rsp_is_final      = rsp_ff.is_final;
   assign rsp_parse_ok      = rsp_ff.ok;

endmodule

FILE: hw/rtl/dpl_checker.sv
module dpl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_segment_value,
   input logic        rsp_has_segment,
   input logic        rsp_is_final,
   input logic        rsp_parse_ok
);

   // A stalled result stays in place unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_segment_value) &&
      $stable(rsp_has_segment) && $stable(rsp_is_final) && $stable(rsp_parse_ok))
      else $error("stalled result changed");

   // Success is reported only on the final result.
   a_ok_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_final |-> !rsp_parse_ok)
      else $error("parse_ok on a non-final result");

   // A final result carries a segment exactly when the text is accepted.
   a_final_seg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_final |-> (rsp_parse_ok == rsp_has_segment))
      else $error("final result segment and status disagree");

   // A result without a segment shows a zero value.
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_segment |-> (rsp_segment_value == 32'd0))
      else $error("value present without a segment");

endmodule

bind decimal_path_list_parser dpl_checker u_dpl_checker (.*);

FILE: test/tb_decimal_path_list_parser.sv
module tb_decimal_path_list_parser;
   import dpl_pkg::*;

   // Largest legal segment for the configured segment width.
   localparam logic [63:0] SEG_LIMIT   = {64{1'b1}} >> (64 - SEG_WIDTH);
   // Cycle budget for the whole run. The slowest correct run stays well within
   // it, even with the long output hold-off included.
   localparam int          CYCLE_LIMIT = 200000;
   // Length of the output hold-off used to back the block up.
   localparam int          HOLD_CYCLES = 400;
   // Bytes that tend to hit interesting branches of the parser.
   localparam string       NOISE_POOL  = "0123456789 ;{}\t";

   // One expected transfer on the result channel.
   typedef struct {
      out_type value;
      logic    has_seg;
      logic    fin;
      logic    ok;
   } seg_report_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code    = 8'h00;
   logic        req_is_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [31:0] rsp_segment_value;
   logic        rsp_has_segment;
   logic        rsp_is_final;
   logic        rsp_parse_ok;

   // Parser state as the block should see it after every accepted byte.
   phase_type   exp_phase  = PH_LEAD;
   logic        exp_braced = 1'b0;
   logic [63:0] exp_acc    = '0;
   logic        exp_failed = 1'b0;

   seg_report_type pending_results[$];
   logic [7:0]     text_buf[$];

   int   error_count    = 0;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic holding        = 1'b0;
   event hold_go;

   decimal_path_list_parser u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_is_last_char (req_is_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_segment_value(rsp_segment_value),
      .rsp_has_segment  (rsp_has_segment),
      .rsp_is_final     (rsp_is_final),
      .rsp_parse_ok     (rsp_parse_ok)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Parser prediction
   // ---------------------------------------------------------------------

   // The six C whitespace bytes: tab, newline, vertical tab, form feed,
   // carriage return and space.
   function automatic logic is_space(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic piece_has_digits();
      return exp_phase == PH_DIGITS || exp_phase == PH_POST;
   endfunction

   function automatic void clear_parse();
      exp_phase  = PH_LEAD;
      exp_braced = 1'b0;
      exp_acc    = '0;
      exp_failed = 1'b0;
   endfunction

   // Moves the parse state over one byte. Once the text has failed, nothing
   // changes until the last byte clears the state.
   function automatic void advance_parse(logic [7:0] c);
      logic        digit;
      logic [63:0] d;
      digit = c >= CH_ZERO && c <= CH_NINE;
      d     = 64'(c - CH_ZERO);
      if (exp_failed)
         return;
      if (exp_phase == PH_LEAD) begin
         if (is_space(c))
            return;
         // An opening brace is legal only as the first non-space byte.
         if (c == CH_LBRACE) begin
            exp_braced = 1'b1;
            exp_phase  = PH_PRE;
            return;
         end
         exp_phase = PH_PRE;
      end
      if (c == CH_SEMI) begin
         if (!piece_has_digits())
            exp_failed = 1'b1;
         exp_phase = PH_PRE;
         return;
      end
      case (exp_phase) inside
         PH_PRE: begin
            if (is_space(c))
               return;
            if (digit) begin
               exp_acc   = d;
               exp_phase = PH_DIGITS;
               return;
            end
            exp_failed = 1'b1;
         end
         PH_DIGITS, PH_POST: begin
            if (is_space(c)) begin
               exp_phase = PH_POST;
               return;
            end
            // A digit after whitespace inside a piece is a bad byte.
            if (digit && exp_phase == PH_DIGITS) begin
               // Overflow fails the text rather than saturating.
               if (exp_acc > (SEG_LIMIT - d) / 64'd10)
                  exp_failed = 1'b1;
               else
                  exp_acc = exp_acc * 64'd10 + d;
               return;
            end
            if (c == CH_RBRACE && exp_braced) begin
               exp_phase = PH_CLOSED;
               return;
            end
            exp_failed = 1'b1;
         end
         default: begin
            // After the closing brace only whitespace may follow.
            if (!is_space(c))
               exp_failed = 1'b1;
         end
      endcase
   endfunction

   // Works out what one accepted byte produces: a report at each separator
   // that is not the last byte, and a final report at the last byte.
   function automatic void predict_parse_result(logic [7:0] c, logic last);
      seg_report_type r;
      logic           good;
      if (!last) begin
         if (c == CH_SEMI) begin
            good      = !exp_failed && piece_has_digits();
            r.value   = good ? exp_acc[OUT_W-1:0] : '0;
            r.has_seg = good;
            r.fin     = 1'b0;
            r.ok      = 1'b0;
            advance_parse(c);
            exp_acc = '0;
            pending_results.insert(pending_results.size(), r);
         end else begin
            advance_parse(c);
         end
      end else begin
         advance_parse(c);
         good      = !exp_failed &&
                     (exp_braced ? exp_phase == PH_CLOSED : piece_has_digits());
         r.value   = good ? exp_acc[OUT_W-1:0] : '0;
         r.has_seg = good;
         r.fin     = 1'b1;
         r.ok      = good;
         pending_results.insert(pending_results.size(), r);
         clear_parse();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result checking and receiver stalls
   // ---------------------------------------------------------------------

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // Outputs are read right after the rising edge, before any register of the
   // block has moved, so the values seen are the ones that made the transfer.
   // The stall for the next cycle is decided in the same block, so each step
   // gets exactly one assignment to it.
   always @(posedge clock) begin
      seg_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual value %0h seg %0b fin %0b ok %0b",
                     $time, rsp_segment_value, rsp_has_segment, rsp_is_final, rsp_parse_ok);
         end else begin
            want = pending_results.pop_front();
            check_field("segment_value", want.value, rsp_segment_value);
            check_field("has_segment", 32'(want.has_seg), 32'(rsp_has_segment));
            check_field("is_final", 32'(want.fin), 32'(rsp_is_final));
            check_field("parse_ok", 32'(want.ok), 32'(rsp_parse_ok));
         end
      end
      rsp_stall <= holding || ($urandom_range(99) < recv_stall_pct);
   end

   // The long hold-off runs on its own, counted in clock cycles, so the
   // sender keeps offering bytes while the result side is blocked.
   always begin
      @(hold_go);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   // Watchdog on the total run length.
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("decimal_path_list_parser test failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Sends one byte. Idle cycles come first; the valid is only lowered in a
   // step where it is not raised again, and the payload holds while stalled.
   // The byte is predicted at the edge where the transfer takes place.
   task automatic send_byte(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_char_code    <= c;
      req_is_last_char <= last;
      do
         @(posedge clock);
      while (req_stall);
      predict_parse_result(c, last);
   endtask

   // Appends one byte to the text buffer.
   function automatic void append_byte(logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endfunction

   // Sends the text held in the buffer, marking its final byte as the last.
   task automatic send_buffer();
      for (int i = 0; i < text_buf.size(); i++)
         send_byte(text_buf[i], i == text_buf.size() - 1);
   endtask

   task automatic send_string(input string s);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++)
         append_byte(s[i]);
      send_buffer();
   endtask

   // The sender drops its valid and pauses here until every expected result
   // has come back, so the last byte is not offered a second time.
   task automatic await_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] noise_byte();
      if ($urandom_range(1))
         return 8'($urandom_range(255));
      return NOISE_POOL[$urandom_range(NOISE_POOL.len() - 1)];
   endfunction

   // Mostly no whitespace, sometimes one or two of the six whitespace bytes.
   function automatic void add_space();
      int k;
      if ($urandom_range(9) < 7)
         return;
      repeat ($urandom_range(1, 2)) begin
         k = $urandom_range(5);
         append_byte(k == 5 ? CH_SPACE : CH_TAB + 8'(k));
      end
   endfunction

   // Adds one decimal segment. Values lean toward the edges: zero, the
   // largest legal segment, one past it, and values far beyond it.
   function automatic void add_number();
      logic [63:0] v;
      string       s;
      int          kind;
      kind = $urandom_range(9);
      case (kind) inside
         0, 1, 2, 3: v = 64'($urandom_range(999));
         4:          v = 64'($urandom);
         5:          v = SEG_LIMIT;
         6:          v = SEG_LIMIT + 64'd1;
         7:          v = {$urandom, $urandom};
         8:          v = '0;
         default:    v = 64'($urandom_range(9));
      endcase
      s = $sformatf("%0d", v);
      if (kind == 9 || $urandom_range(9) == 0)
         s = {"00", s};
      if (kind == 5 && $urandom_range(1))
         s = {s, "7"};
      for (int i = 0; i < s.len(); i++)
         append_byte(s[i]);
   endfunction

   // Builds one random text. Most are well-formed lists with random content,
   // some of those get one byte replaced, dropped or inserted, and the rest
   // are short runs of noise.
   function automatic void make_random_text();
      int   mode;
      int   pos;
      logic braced;
      text_buf.delete();
      mode = $urandom_range(99);
      if (mode < 80) begin
         braced = $urandom_range(3) == 0;
         add_space();
         if (braced)
            append_byte(CH_LBRACE);
         add_space();
         for (int i = $urandom_range(1, 4); i > 0; i--) begin
            add_number();
            add_space();
            if (i > 1) begin
               append_byte(CH_SEMI);
               add_space();
            end
         end
         if (braced)
            append_byte(CH_RBRACE);
         add_space();
         if (mode >= 62) begin
            pos = $urandom_range(text_buf.size() - 1);
            case ($urandom_range(2))
               0:       text_buf[pos] = noise_byte();
               1:       text_buf.delete(pos);
               default: text_buf.insert(pos, noise_byte());
            endcase
            if (text_buf.size() == 0)
               append_byte(noise_byte());
         end
      end else begin
         repeat ($urandom_range(1, 6))
            append_byte(noise_byte());
      end
   endfunction

   task automatic run_random_texts(input int n_bytes, input int sidle, input int rstall);
      int sent;
      send_idle_pct  = sidle;
      recv_stall_pct = rstall;
      sent           = 0;
      while (sent < n_bytes) begin
         make_random_text();
         sent += text_buf.size();
         send_buffer();
      end
      await_results();
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Short texts aimed at each rule of the grammar in turn.
   task automatic test_directed_cases();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_string("\t12\n");   // whitespace around a lone segment
      send_string("{9}");      // braced list
      send_string("1;");       // separator as the last byte
      send_string(";");        // empty piece
      send_string("1 2");      // digit after whitespace inside a piece
      send_string("}");        // closing brace in unbraced text
      send_string("{1}x");     // non-space byte after the closing brace
      send_string("{1");       // braced text without its closing brace
      send_string("{{");       // opening brace that is not the first byte
      // Ten times the largest segment: the parse must fail, not saturate.
      send_string({$sformatf("%0d", SEG_LIMIT), "0"});
      // Byte with every bit set, as a lone bad byte.
      text_buf.delete();
      append_byte(8'hFF);
      send_buffer();
      await_results();
   endtask

   task automatic test_random_no_idle();
      run_random_texts(190, 0, 0);
   endtask

   task automatic test_random_sender_idle();
      run_random_texts(160, 61, 0);
   endtask

   task automatic test_random_receiver_stall();
      run_random_texts(160, 0, 61);
   endtask

   task automatic test_random_both_idle();
      run_random_texts(140, 22, 22);
   endtask

   // Blocks the result side for a long stretch while a separator-heavy text
   // streams in at full rate, so the block fills up and stalls its input.
   task automatic test_output_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      -> hold_go;
      text_buf.delete();
      repeat (60) begin
         append_byte(CH_ZERO + 8'($urandom_range(9)));
         append_byte(CH_SEMI);
      end
      append_byte(CH_NINE);
      send_buffer();
      await_results();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_no_idle();
      test_output_backpressure();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();

      // Everything has been sent; drain, then let the clock run on so a stray
      // extra result would still be caught.
      await_results();
      repeat (8) @(posedge clock);

      if (error_count == 0)
         $display("decimal_path_list_parser test passed");
      else
         $display("decimal_path_list_parser test failed");
      $finish;
   end

endmodule
